>>> sv/pfss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pfss_pkg;
  localparam int unsigned GainW = 48;
  localparam int unsigned ValW = 17;
  localparam logic [ValW-1:0] OneQ16 = 17'd65536;
  localparam logic [34:0] DriveSat = {35{1'b1}};
  localparam logic [GainW-1:0] DiffRst = 48'd140737488355;
  localparam logic [GainW-1:0] BarRst = 48'd28147498;
  localparam logic [GainW-1:0] DrvRst = 48'd1407375;
  localparam logic [GainW-1:0] OffRst = 48'd281474977;
  localparam logic [1:0] RegDiff = 2'd0;
  localparam logic [1:0] RegBar = 2'd1;
  localparam logic [1:0] RegDrv = 2'd2;
  localparam logic [1:0] RegOff = 2'd3;

  typedef struct packed {
    logic [16:0] cell_value;
    logic        row_end;
  } in_req_t;

  typedef struct packed {
    logic [16:0] new_value;
    logic        was_clamped;
    logic        last_of_row;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CALC, ST_WAIT, ST_OUT1, ST_OUT2
  } state_e;

  typedef struct packed {
    logic start;
  } cmd_t;

  typedef struct packed {
    logic done;
  } stat_t;
endpackage
`default_nettype wire

>>> sv/pfss_calc.sv
`timescale 1ns / 1ps
`default_nettype none
// Cell update datapath: a step sequencer over a shared 25x25 multiplier,
// then a restoring divider, one quotient bit per cycle.
module pfss_calc (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire pfss_pkg::cmd_t cmd_i,
  input  wire logic [16:0] left_i,
  input  wire logic [16:0] cent_i,
  input  wire logic [16:0] right_i,
  input  wire logic [47:0] diff_i,
  input  wire logic [47:0] bar_i,
  input  wire logic [47:0] drv_i,
  input  wire logic [47:0] off_i,
  output pfss_pkg::stat_t  stat_o,
  output logic [16:0]      val_o,
  output logic             clamp_o
);
  // multiply phase: 8 products x 4 partial-product steps; divide: 35 steps
  logic [5:0]   step_q, step_d;
  logic         busy_q, div_q, sat_q, neg_q;
  logic [32:0]  p2_q;
  logic [48:0]  p3_q, p4_q, f_q, fp_q;
  logic [49:0]  s_q;
  logic [17:0]  mag_q;
  logic [99:0]  acc_q;
  logic [102:0] num_q;
  logic [101:0] den_q;
  logic [32:0]  bterm_q, dterm_q;
  logic [34:0]  q_q;
  logic [2:0]   mi;
  logic [1:0]   ai;
  logic [49:0]  opa, opb;
  logic [24:0]  ma, mb;
  logic [49:0]  mp;
  logic [99:0]  mp_w, prod;
  logic [17:0]  lap_p, lap_n;
  logic [16:0]  p, omp;
  logic [50:0]  f_w;
  logic [102:0] lim, rem;
  logic         ge;
  logic [39:0]  v, vs;
  logic [23:0]  vq;

  assign p = cent_i;
  assign omp = pfss_pkg::OneQ16 - p;
  assign lap_p = {1'b0, left_i} + {1'b0, right_i};
  assign lap_n = {cent_i, 1'b0};
  assign mi = step_q[4:2];
  assign ai = step_q[1:0];

  // m0 p*p, m1 p2*p, m2 p3*p (p4), m3 p2*(1-p), m4 drv*fp, m5 s*s,
  // m6 bar*fp, m7 diff*|lap|
  always_comb begin
    case (mi)
      3'd0: begin opa = {33'd0, p}; opb = {33'd0, p}; end
      3'd1: begin opa = {17'd0, p2_q}; opb = {33'd0, p}; end
      3'd2: begin opa = {1'b0, p3_q}; opb = {33'd0, p}; end
      3'd3: begin opa = {17'd0, p2_q}; opb = {33'd0, omp}; end
      3'd4: begin opa = {2'd0, drv_i}; opb = {1'b0, fp_q}; end
      3'd5: begin opa = s_q; opb = s_q; end
      3'd6: begin opa = {2'd0, bar_i}; opb = {1'b0, fp_q}; end
      default: begin opa = {2'd0, diff_i}; opb = {32'd0, mag_q}; end
    endcase
  end

  assign ma = ai[0] ? opa[49:25] : opa[24:0];
  assign mb = ai[1] ? opb[49:25] : opb[24:0];
  assign mp = ma * mb;

  always_comb begin
    case (ai)
      2'd0: mp_w = {50'd0, mp};
      2'd3: mp_w = {mp, 50'd0};
      default: mp_w = {25'd0, mp, 25'd0};
    endcase
  end

  assign prod = acc_q + mp_w;

  // f = 4p3 - 3p4, never negative for p <= 1.0
  assign f_w = {p3_q, 2'b0} - {1'b0, p4_q, 1'b0} - {2'b0, p4_q};
  assign lim = {prod, 3'b0};
  assign ge = num_q >= {1'b0, den_q};
  assign rem = ge ? num_q - {1'b0, den_q} : num_q;

  assign v = {7'd0, p, 16'd0} + {5'd0, q_q} + {7'd0, bterm_q};
  assign vs = neg_q ? v - {7'd0, dterm_q} : v + {7'd0, dterm_q};
  assign vq = vs[39:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; div_q <= 1'b0; step_q <= '0; stat_o <= '0;
    end else begin
      stat_o.done <= busy_q && div_q && (step_q == 6'd34);
      if (cmd_i.start) begin
        busy_q <= 1'b1; div_q <= 1'b0; step_q <= '0;
      end else if (busy_q && !div_q) begin
        if (step_q == 6'd31) begin
          div_q <= 1'b1; step_q <= '0;
        end else begin
          step_q <= step_d;
        end
      end else if (busy_q) begin
        if (step_q == 6'd34) begin
          busy_q <= 1'b0; div_q <= 1'b0; step_q <= '0;
        end else begin
          step_q <= step_d;
        end
      end
    end
  end
  assign step_d = step_q + 6'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      acc_q <= '0;
      q_q <= '0;
      sat_q <= 1'b0;
      neg_q <= lap_p < lap_n;
      mag_q <= (lap_p < lap_n) ? lap_n - lap_p : lap_p - lap_n;
    end else if (busy_q && !div_q) begin
      if (ai == 2'd3) begin
        acc_q <= '0;
        case (mi)
          3'd0: p2_q <= prod[32:0];
          3'd1: p3_q <= prod[48:0];
          3'd2: p4_q <= prod[64:16];
          3'd3: begin
            // f' = 12 * p2 * (1 - p)
            fp_q <= {prod[45:0], 3'b0} + {1'b0, prod[45:0], 2'b0};
            f_q <= f_w[48:0];
          end
          3'd4: begin
            num_q <= {6'd0, prod[96:0]};
            s_q <= {1'b0, f_q} + {2'd0, off_i};
          end
          3'd5: begin
            den_q <= {prod, 2'b0};
            // ratio of 8.0 or more, or zero denominator
            if (num_q >= lim) begin
              sat_q <= 1'b1;
              q_q <= pfss_pkg::DriveSat;
            end
          end
          3'd6: bterm_q <= prod[96:64];
          default: dterm_q <= prod[64:32];
        endcase
      end else begin
        acc_q <= prod;
      end
    end else if (busy_q && !sat_q) begin
      q_q <= {q_q[33:0], ge};
      num_q <= {rem[101:0], 1'b0};
    end
  end

  always_comb begin
    clamp_o = 1'b0;
    val_o = vq[16:0];
    if (vs[39]) begin
      clamp_o = 1'b1; val_o = '0;
    end else if (vq > {7'd0, pfss_pkg::OneQ16}) begin
      clamp_o = 1'b1; val_o = pfss_pkg::OneQ16;
    end
  end
endmodule
`default_nettype wire

>>> sv/pfss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pfss_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  input  wire logic need_calc_i,
  input  wire logic has_res_i,
  input  wire logic two_i,
  input  wire logic out_ready_i,
  input  wire pfss_pkg::stat_t stat_i,
  output pfss_pkg::cmd_t cmd_o,
  output logic in_ready_o,
  output logic out_valid_o,
  output logic sel_second_o
);
  pfss_pkg::state_e state_q, state_d;
  logic two_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin state_q <= pfss_pkg::ST_IDLE; two_q <= 1'b0; end
    else begin
      state_q <= state_d;
      if (in_fire_i) two_q <= two_i;
    end
  end
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfss_pkg::ST_IDLE:
        if (in_fire_i && has_res_i)
          state_d = need_calc_i ? pfss_pkg::ST_CALC : pfss_pkg::ST_OUT1;
      pfss_pkg::ST_CALC: state_d = pfss_pkg::ST_WAIT;
      pfss_pkg::ST_WAIT: if (stat_i.done) state_d = pfss_pkg::ST_OUT1;
      pfss_pkg::ST_OUT1:
        if (out_ready_i) state_d = two_q ? pfss_pkg::ST_OUT2 : pfss_pkg::ST_IDLE;
      pfss_pkg::ST_OUT2: if (out_ready_i) state_d = pfss_pkg::ST_IDLE;
      default: state_d = pfss_pkg::ST_IDLE;
    endcase
  end
  always_comb begin
    cmd_o = '0;
    cmd_o.start = state_q == pfss_pkg::ST_CALC;
    in_ready_o = state_q == pfss_pkg::ST_IDLE;
    out_valid_o = state_q == pfss_pkg::ST_OUT1 || state_q == pfss_pkg::ST_OUT2;
    sel_second_o = state_q == pfss_pkg::ST_OUT2;
  end
endmodule
`default_nettype wire

>>> sv/phase_field_stencil_step.sv
`timescale 1ns / 1ps
`default_nettype none
// Phase-field stencil step: one explicit Euler update of a 1-D damage row.
// Input channel (in_valid_i/in_ready_o) takes one cell request per item:
// a Q1.16 cell value and a row_end flag. Output channel
// (out_valid_o/out_ready_i) gives zero to two result requests per input,
// trailing the input stream by one cell.
// Interior cells run through a shared multiplier sequencer and a
// restoring divider (one quotient bit per cycle); the result is valid
// when the divider is done, and the next request is taken once all
// results of the item are accepted. Boundary results are valid the
// cycle after the request, and the next request is taken once they
// are accepted. A first cell that is not a row end gives no result
// and the input stays ready. One item in flight. The user writes gains
// through cfg_we_i/cfg_idx_i/cfg_data_i only while idle; not enforced.
// Reset restores default gains and clears the row state.
// A stalled receiver simply holds the block in its output state;
// no new input is taken until all results of the item are gone.
module phase_field_stencil_step (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire pfss_pkg::in_req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output pfss_pkg::out_req_t out_data_o,
  input  wire logic cfg_we_i,
  input  wire logic [1:0] cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);
  logic [47:0] diff_q, bar_q, drv_q, off_q;
  logic [16:0] left_q, cent_q, right_q, x;
  logic [1:0]  phase_q;
  logic        end_q, fire, sel2, clamp;
  logic [16:0] val;
  logic [1:0]  out_ph_q;
  logic [16:0] first_q;
  pfss_pkg::cmd_t cmd;
  pfss_pkg::stat_t stat;

  assign fire = in_valid_i && in_ready_o;
  assign x = in_data_i.cell_value > pfss_pkg::OneQ16 ? pfss_pkg::OneQ16
                                                    : in_data_i.cell_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_q <= pfss_pkg::DiffRst; bar_q <= pfss_pkg::BarRst;
      drv_q <= pfss_pkg::DrvRst; off_q <= pfss_pkg::OffRst;
      left_q <= '0; cent_q <= '0; phase_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pfss_pkg::RegDiff: diff_q <= cfg_data_i;
          pfss_pkg::RegBar:  bar_q <= cfg_data_i;
          pfss_pkg::RegDrv:  drv_q <= cfg_data_i;
          pfss_pkg::RegOff:  off_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire) begin
        // snapshot for the calc: left/center stay until next fire
        if (in_data_i.row_end) phase_q <= 2'd0;
        else begin
          if (phase_q == 2'd1 || phase_q == 2'd2) begin
            left_q <= cent_q; phase_q <= 2'd2;
          end else phase_q <= 2'd1;
          cent_q <= x;
        end
      end
    end
  end

  // operand copies for the calc and the result path
  logic [16:0] cl_q, cc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ph_q <= '0; end_q <= 1'b0; right_q <= '0; cl_q <= '0; cc_q <= '0;
      first_q <= '0;
    end else if (fire) begin
      out_ph_q <= phase_q; end_q <= in_data_i.row_end; right_q <= x;
      cl_q <= left_q; cc_q <= cent_q; first_q <= cent_q;
    end
  end

  logic has_first, need, has_res;
  assign has_first = phase_q == 2'd1 || phase_q == 2'd2;
  assign need = phase_q == 2'd2;
  // a held cell or a row end releases at least one result
  assign has_res = has_first || in_data_i.row_end;

  pfss_calc u_calc (
    .clk_i, .rst_ni, .cmd_i(cmd), .left_i(cl_q), .cent_i(cc_q),
    .right_i(right_q), .diff_i(diff_q), .bar_i(bar_q), .drv_i(drv_q),
    .off_i(off_q), .stat_o(stat), .val_o(val), .clamp_o(clamp)
  );

  logic two;
  assign two = has_first && in_data_i.row_end;

  pfss_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .need_calc_i(need), .has_res_i(has_res),
    .two_i(two), .out_ready_i(out_ready_i), .stat_i(stat), .cmd_o(cmd),
    .in_ready_o(in_ready_o), .out_valid_o(out_valid_o), .sel_second_o(sel2)
  );

  // first result: previous cell (interior or first); else the ending cell
  always_comb begin
    out_data_o = '0;
    if (sel2 || out_ph_q == 2'd0 || out_ph_q == 2'd3) begin
      out_data_o.new_value = right_q;
      out_data_o.last_of_row = 1'b1;
    end else if (out_ph_q == 2'd2) begin
      out_data_o.new_value = val;
      out_data_o.was_clamped = clamp;
    end else begin
      out_data_o.new_value = first_q;
    end
    if (!sel2 && (out_ph_q == 2'd0 || out_ph_q == 2'd3) && !end_q)
      out_data_o = '0;
  end
endmodule
`default_nettype wire

>>> bench/phase_field_stencil_step_tb.sv
`timescale 1ns / 1ps
module phase_field_stencil_step_tb;

  // Row tracking of the stencil: which cells are held while waiting
  // for the right neighbor.
  typedef enum logic [1:0] {
    RP_FIRST,       // expecting the first cell of a row
    RP_HOLD_FIRST,  // first cell held, not yet emitted
    RP_HOLD_INNER   // interior candidate held together with its left neighbor
  } row_phase_e;

  // Directed stimulus row. Where the result is obvious (pass-through of a
  // boundary cell) the final result of the request is typed in.
  typedef struct {
    logic [16:0]        cval;
    logic               row_end;
    logic               typed;
    pfss_pkg::out_req_t typed_res;
  } dir_row_t;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned DrainCycles = 120;  // idle wait after the last owed result
  localparam int unsigned StallLimit = 5000;  // longest hold plus a few cells

  logic clk, rst_n;
  logic in_valid, in_ready;
  pfss_pkg::in_req_t in_data;
  logic out_valid, out_ready;
  pfss_pkg::out_req_t out_data;
  logic cfg_we;
  logic [1:0] cfg_idx;
  logic [47:0] cfg_data;

  phase_field_stencil_step i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #HalfPeriod;
    clk = 1'b0;
    #HalfPeriod;
  end

  // Predictor state: its own copy of the gains and of the row window.
  logic [47:0] diff_gain, bar_gain, drv_gain, soft_off;
  logic [16:0] left_cell, held_cell;
  row_phase_e  row_ph;

  pfss_pkg::out_req_t pending_res[$];  // results still owed by the block
  int unsigned err_cnt;
  int unsigned hold_left;       // long receiver hold, counted by the receiver
  logic        calm;            // no random idling on either side

  // One explicit Euler step of an interior cell, all in integer fixed point.
  function automatic logic [16:0] euler_cell(input logic [16:0] lft, input logic [16:0] c,
                                             input logic [16:0] rgt, output logic clp);
    logic [63:0]  p, p2, p3, p4, f, fp, s, mag, q, bar;
    logic [127:0] num, den, prod;
    longint       lap, dterm, v;
    p = 64'(c);
    p2 = p * p;
    p3 = p2 * p;
    p4 = (p3 >> 16) * p + (((p3 & 64'hFFFF) * p) >> 16);
    f = 64'd4 * p3 - 64'd3 * p4;
    fp = 64'd12 * p2 * (64'd65536 - p);
    lap = longint'(lft) + longint'(rgt) - 2 * longint'(c);
    mag = (lap < 0) ? 64'(-lap) : 64'(lap);
    prod = 128'(diff_gain) * 128'(mag);
    dterm = longint'(prod[95:32]);
    // softened ratio term, restoring division with saturation
    num = 128'(drv_gain) * 128'(fp);
    s = f + 64'(soft_off);
    den = 128'(s) * 128'(s);
    q = 64'd0;
    if (num >= (den << 3)) begin
      q = 64'(pfss_pkg::DriveSat);
    end else begin
      den = den << 2;
      for (int i = 0; i < 35; i++) begin
        q = q << 1;
        if (num >= den) begin
          num = num - den;
          q[0] = 1'b1;
        end
        num = num << 1;
      end
    end
    prod = 128'(bar_gain) * 128'(fp);
    bar = prod[127:64];
    v = longint'(p << 16) + longint'(q) + longint'(bar);
    v = (lap < 0) ? v - dterm : v + dterm;
    clp = 1'b0;
    if (v < 0) begin
      clp = 1'b1;
      return 17'd0;
    end
    q = 64'(v) >> 16;
    if (q > 64'(pfss_pkg::OneQ16)) begin
      clp = 1'b1;
      return pfss_pkg::OneQ16;
    end
    return q[16:0];
  endfunction

  // Advance the row window by one accepted cell and queue what it releases.
  function automatic void predict_cell(input pfss_pkg::in_req_t req);
    logic [16:0]        x;
    logic               clp;
    pfss_pkg::out_req_t r;
    x = (req.cell_value > pfss_pkg::OneQ16) ? pfss_pkg::OneQ16 : req.cell_value;
    if (row_ph == RP_HOLD_FIRST) begin
      r = '{new_value: held_cell, was_clamped: 1'b0, last_of_row: 1'b0};
      pending_res.push_back(r);
    end else if (row_ph == RP_HOLD_INNER) begin
      r.new_value = euler_cell(left_cell, held_cell, x, clp);
      r.was_clamped = clp;
      r.last_of_row = 1'b0;
      pending_res.push_back(r);
    end
    if (req.row_end) begin
      r = '{new_value: x, was_clamped: 1'b0, last_of_row: 1'b1};
      pending_res.push_back(r);
      row_ph = RP_FIRST;
    end else begin
      if (row_ph == RP_FIRST) begin
        row_ph = RP_HOLD_FIRST;
      end else begin
        left_cell = held_cell;
        row_ph = RP_HOLD_INNER;
      end
      held_cell = x;
    end
  endfunction

  // Offer one cell request; returns at the edge where it is taken.
  task automatic send_cell(input logic [16:0] cval, input logic row_end);
    if (!calm && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cell_value: cval, row_end: row_end};
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_cell('{cell_value: cval, row_end: row_end});
  endtask

  // Drop valid and let everything owed drain, plus the block's own latency.
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_gain(input logic [1:0] idx, input logic [47:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pfss_pkg::RegDiff: diff_gain = val;
      pfss_pkg::RegBar:  bar_gain = val;
      pfss_pkg::RegDrv:  drv_gain = val;
      default: soft_off = val;
    endcase
  endtask

  function automatic logic [47:0] rand_gain();
    logic [63:0] w;
    w = {$urandom(), $urandom()} >> $urandom_range(0, 47);
    return w[47:0];
  endfunction

  function automatic logic [16:0] rand_cell();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 8) return 17'd0;
    if (k < 16) return pfss_pkg::OneQ16;
    if (k < 20) return 17'($urandom_range(131071, 65537));
    if (k < 30) return 17'($urandom_range(65536, 60000));
    return 17'($urandom_range(65536));
  endfunction

  // Mostly well-formed rows of a few cells, with the odd lone cell.
  task automatic random_rows(input int unsigned n_cells);
    int unsigned sent, len;
    sent = 0;
    while (sent < n_cells) begin
      len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
      for (int unsigned i = 0; i < len; i++) begin
        send_cell(rand_cell(), i == len - 1);
      end
      sent += len;
    end
  endtask

  // Receiver: random stalls, or a long hold when requested.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 6);
    end
  end

  // Result check; outputs and ready are stable at the falling edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, out_data);
        err_cnt++;
      end else begin
        if (out_data.new_value !== pending_res[0].new_value) begin
          $display("%0t: new_value expected %0d actual %0d", $realtime,
                   pending_res[0].new_value, out_data.new_value);
          err_cnt++;
        end
        if (out_data.was_clamped !== pending_res[0].was_clamped) begin
          $display("%0t: was_clamped expected %0b actual %0b", $realtime,
                   pending_res[0].was_clamped, out_data.was_clamped);
          err_cnt++;
        end
        if (out_data.last_of_row !== pending_res[0].last_of_row) begin
          $display("%0t: last_of_row expected %0b actual %0b", $realtime,
                   pending_res[0].last_of_row, out_data.last_of_row);
          err_cnt++;
        end
        void'(pending_res.pop_front());
      end
    end
  end

  // Watchdog: cycles without any handshake on either channel.
  int unsigned quiet_cycles;
  always @(negedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $realtime, quiet_cycles);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  dir_row_t dir_tab[$];

  function automatic dir_row_t drow(input logic [16:0] cval, input logic row_end,
                                    input logic typed, input logic [16:0] val);
    dir_row_t d;
    d.cval = cval;
    d.row_end = row_end;
    d.typed = typed;
    d.typed_res = '{new_value: val, was_clamped: 1'b0, last_of_row: 1'b1};
    return d;
  endfunction

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_idx = pfss_pkg::RegDiff;
    cfg_data = '0;
    err_cnt = 0;
    hold_left = 0;
    calm = 1'b0;
    diff_gain = pfss_pkg::DiffRst;
    bar_gain = pfss_pkg::BarRst;
    drv_gain = pfss_pkg::DrvRst;
    soft_off = pfss_pkg::OffRst;
    left_cell = '0;
    held_cell = '0;
    row_ph = RP_FIRST;

    // lone cells pass through; input above 1.0 is taken as 1.0 unflagged
    dir_tab.push_back(drow(17'd12345, 1'b1, 1'b1, 17'd12345));
    dir_tab.push_back(drow(17'd0, 1'b1, 1'b1, 17'd0));
    dir_tab.push_back(drow(pfss_pkg::OneQ16, 1'b1, 1'b1, pfss_pkg::OneQ16));
    dir_tab.push_back(drow(17'h1FFFF, 1'b1, 1'b1, pfss_pkg::OneQ16));
    // a long row over the corners of the cell range
    dir_tab.push_back(drow(17'd100000, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd0, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(pfss_pkg::OneQ16, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd32768, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd1, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd65535, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'h1FFFF, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd20000, 1'b1, 1'b1, 17'd20000));
    // two-cell row: both boundary cells
    dir_tab.push_back(drow(17'd40000, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd50000, 1'b1, 1'b1, 17'd50000));
    // 0 / 1.0 / 0 pulls the center down hard; 1.0 / 0 / 1.0 pushes it up
    dir_tab.push_back(drow(17'd0, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(pfss_pkg::OneQ16, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(17'd0, 1'b0, 1'b0, 17'd0));
    dir_tab.push_back(drow(pfss_pkg::OneQ16, 1'b1, 1'b1, pfss_pkg::OneQ16));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at reset gains.
    foreach (dir_tab[i]) begin
      send_cell(dir_tab[i].cval, dir_tab[i].row_end);
      if (dir_tab[i].typed && pending_res[$] !== dir_tab[i].typed_res) begin
        $display("%0t: table row %0d expected %p actual %p", $realtime, i,
                 dir_tab[i].typed_res, pending_res[$]);
        err_cnt++;
      end
    end
    random_rows(60);

    // Receiver holds off for a long while; the sender keeps offering.
    hold_left = 400;
    random_rows(40);
    quiesce();

    // All gains at full scale: saturated quotient, clamping both ways.
    write_gain(pfss_pkg::RegDiff, 48'hFFFF_FFFF_FFFF);
    write_gain(pfss_pkg::RegBar, 48'hFFFF_FFFF_FFFF);
    write_gain(pfss_pkg::RegDrv, 48'hFFFF_FFFF_FFFF);
    write_gain(pfss_pkg::RegOff, 48'hFFFF_FFFF_FFFF);
    for (int i = 0; i < 3; i++) begin
      send_cell(i[0] ? pfss_pkg::OneQ16 : 17'd0, 1'b0);
    end
    send_cell(pfss_pkg::OneQ16, 1'b1);
    random_rows(70);
    quiesce();

    // All zero: zero denominator at p = 0 saturates the ratio term.
    write_gain(pfss_pkg::RegDiff, 48'd0);
    write_gain(pfss_pkg::RegBar, 48'd0);
    write_gain(pfss_pkg::RegDrv, 48'd0);
    write_gain(pfss_pkg::RegOff, 48'd0);
    send_cell(17'd0, 1'b0);
    send_cell(17'd0, 1'b0);
    send_cell(17'd0, 1'b1);
    random_rows(70);
    quiesce();

    // Large diffusion only, then strong barrier with no offset.
    write_gain(pfss_pkg::RegDiff, 48'hFFFF_FFFF_FFFF);
    write_gain(pfss_pkg::RegOff, pfss_pkg::OffRst);
    random_rows(50);
    quiesce();
    write_gain(pfss_pkg::RegDiff, 48'd0);
    write_gain(pfss_pkg::RegBar, 48'h8000_0000_0000);
    write_gain(pfss_pkg::RegDrv, pfss_pkg::DrvRst);
    write_gain(pfss_pkg::RegOff, 48'd0);
    random_rows(50);
    quiesce();

    // Random gains, several settings, one of them with no idling at all.
    for (int ph = 0; ph < 3; ph++) begin
      write_gain(pfss_pkg::RegDiff, rand_gain());
      write_gain(pfss_pkg::RegBar, rand_gain());
      write_gain(pfss_pkg::RegDrv, rand_gain());
      write_gain(pfss_pkg::RegOff, rand_gain());
      calm = (ph == 1);
      random_rows(50);
      quiesce();
    end
    calm = 1'b0;

    // Back to reset gains.
    write_gain(pfss_pkg::RegDiff, pfss_pkg::DiffRst);
    write_gain(pfss_pkg::RegBar, pfss_pkg::BarRst);
    write_gain(pfss_pkg::RegDrv, pfss_pkg::DrvRst);
    write_gain(pfss_pkg::RegOff, pfss_pkg::OffRst);
    random_rows(60);
    quiesce();

    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/pfss_pkg.sv
sv/pfss_calc.sv
sv/pfss_ctrl.sv
sv/phase_field_stencil_step.sv
bench/phase_field_stencil_step_tb.sv
